// ----- rtl/core/cam_pkg.sv -----
// Shared types, constants and rounding helpers for the cylindrical annulus map.
package cam_pkg;

  localparam int FRAC_BITS        = 16;  // register / output fraction bits
  localparam int COORD_BITS       = 16;  // parametric input fraction bits
  localparam int TRIG_BITS        = 30;  // CORDIC fraction bits
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int CORDIC_STEPS_MAX = 30;

  localparam int PW  = 72;  // product width
  localparam int RW  = 36;  // radius / height
  localparam int AW  = 24;  // angle, Q8.16
  localparam int CW  = 36;  // CORDIC datapath
  localparam int QW  = 40;  // angle in Q10.30 before reduction
  localparam int KW  = 8;   // turn count
  localparam int PRW = 40;  // trig products

  typedef logic signed [PW-1:0] wide_t;

  localparam logic signed [QW-1:0] Q30_PI      = 40'sd3373259426;
  localparam logic signed [QW-1:0] Q30_TWO_PI  = 40'sd6746518852;
  localparam logic signed [QW-1:0] Q30_HALF_PI = 40'sd1686629713;
  localparam logic signed [CW-1:0] Q30_GAIN    = 36'sd652032874;
  // floor(2^40 / (2*pi * 2^FRAC_BITS)): turn count = (angle * RECIP) >> 40
  localparam logic signed [47:0]   TURN_RECIP  = 48'sd2670176;
  localparam int                   TURN_SHIFT  = 40;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS_MAX] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  localparam wide_t SAT_MAX = wide_t'(64'sd2147483647);
  localparam wide_t SAT_MIN = wide_t'(-64'sd2147483648);

  typedef enum logic [2:0] {
    REG_INNER_RADIUS = 3'd0,
    REG_OUTER_RADIUS = 3'd1,
    REG_BASE_HEIGHT  = 3'd2,
    REG_TOP_HEIGHT   = 3'd3,
    REG_START_ANGLE  = 3'd4,
    REG_END_ANGLE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] angle_coord;
    logic [15:0] radius_coord;
    logic [15:0] height_coord;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] jac_angle_x;
    logic signed [31:0] jac_angle_y;
    logic signed [31:0] jac_radius_x;
    logic signed [31:0] jac_radius_y;
    logic signed [31:0] jac_height_z;
    logic signed [31:0] hess_angle_x;
    logic signed [31:0] hess_angle_y;
    logic signed [31:0] hess_mixed_x;
    logic signed [31:0] hess_mixed_y;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] m;
    logic                 flip;
    logic signed [RW-1:0] rr;
    logic signed [RW-1:0] z;
  } cord_t;

  // round p / 2^sh to nearest, ties away from zero
  function automatic wide_t rnd_shift(input wide_t p, input int unsigned sh);
    wide_t mag;
    wide_t q;
    wide_t half;
    half = wide_t'(1) <<< (sh - 1);
    mag  = p[PW-1] ? -p : p;
    q    = (mag + half) >>> sh;
    return p[PW-1] ? -q : q;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t p);
    logic signed [31:0] r;
    if (p > SAT_MAX)      r = 32'sh7FFFFFFF;
    else if (p < SAT_MIN) r = 32'sh80000000;
    else                  r = p[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/cam_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module cam_cordic import cam_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  cord_t up,
  output logic  dn_valid,
  input  logic  dn_ready,
  output cord_t dn
);

  cord_t            stg  [STEPS];
  cord_t            feed [STEPS+1];
  cord_t            nxt  [STEPS];
  logic [STEPS-1:0] v;
  logic [STEPS-1:0] en;
  logic [STEPS:0]   vfeed;

  assign vfeed = {v, up_valid};

  always_comb begin
    en[STEPS-1] = !v[STEPS-1] || dn_ready;
    for (int i = STEPS - 2; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  always_comb begin
    feed[0] = up;
    for (int i = 0; i < STEPS; i++) begin
      feed[i+1] = stg[i];
      nxt[i]    = feed[i];
      if (!feed[i].m[CW-1]) begin
        nxt[i].x = feed[i].x - (feed[i].y >>> i);
        nxt[i].y = feed[i].y + (feed[i].x >>> i);
        nxt[i].m = feed[i].m - $signed({4'b0, ATAN_Q30[i]});
      end else begin
        nxt[i].x = feed[i].x + (feed[i].y >>> i);
        nxt[i].y = feed[i].y - (feed[i].x >>> i);
        nxt[i].m = feed[i].m + $signed({4'b0, ATAN_Q30[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STEPS; i++) if (en[i]) v[i] <= vfeed[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STEPS; i++) if (en[i]) stg[i] <= nxt[i];
  end

  assign up_ready = en[0];
  assign dn_valid = v[STEPS-1];
  assign dn       = stg[STEPS-1];

endmodule

// ----- rtl/core/cylindrical_annulus_map.sv -----
// Cylindrical annulus map: parametric (angle, radius, height) to position, Jacobian, Hessian.
// Accepts one point per cycle while point_ready is high and returns one result per point,
// in order. Four stages scale the coordinates and reduce the angle to [-pi/2, pi/2], one
// CORDIC stage per micro-rotation gives sine and cosine, and two multiplier stages form
// the products, the last one being the result register. Each stage holds only while the
// stage after it is full and stalled, so bubbles are squeezed out under backpressure.
// Configuration writes take effect at once and are always accepted; write them only while
// no request is in flight.
module cylindrical_annulus_map import cam_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        point_valid,
  output logic        point_ready,
  input  point_t      point,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  // configuration
  logic signed [31:0] r0, r1, h0, h1;
  logic signed [20:0] t0, t1;
  logic signed [32:0] d_r, d_h;
  logic signed [21:0] d_t;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0 <= 32'sd65536;
      r1 <= 32'sd131072;
      h0 <= 32'sd0;
      h1 <= 32'sd65536;
      t0 <= 21'sd0;
      t1 <= 21'sd102944;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INNER_RADIUS: r0 <= cfg_data;
        REG_OUTER_RADIUS: r1 <= cfg_data;
        REG_BASE_HEIGHT:  h0 <= cfg_data;
        REG_TOP_HEIGHT:   h1 <= cfg_data;
        REG_START_ANGLE:  t0 <= cfg_data[20:0];
        REG_END_ANGLE:    t1 <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  assign d_r = {r1[31], r1} - {r0[31], r0};
  assign d_h = {h1[31], h1} - {h0[31], h0};
  assign d_t = {t1[20], t1} - {t0[20], t0};

  // stage control
  logic v_s1, v_s2, v_s3, v_s4, v_p1;
  logic en_s1, en_s2, en_s3, en_s4, en_p1, en_p2;
  logic cord_up_ready, cord_dn_valid;
  cord_t cord_up, cord_dn;

  assign en_p2       = !result_valid || result_ready;
  assign en_p1       = !v_p1 || en_p2;
  assign en_s4       = !v_s4 || cord_up_ready;
  assign en_s3       = !v_s3 || en_s4;
  assign en_s2       = !v_s2 || en_s3;
  assign en_s1       = !v_s1 || en_s2;
  assign point_ready = en_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s1         <= 1'b0;
      v_s2         <= 1'b0;
      v_s3         <= 1'b0;
      v_s4         <= 1'b0;
      v_p1         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en_s1) v_s1 <= point_valid;
      if (en_s2) v_s2 <= v_s1;
      if (en_s3) v_s3 <= v_s2;
      if (en_s4) v_s4 <= v_s3;
      if (en_p1) v_p1 <= cord_dn_valid;
      if (en_p2) result_valid <= v_p1;
    end
  end

  // stage 1: scale coordinates
  logic signed [RW-1:0] s1_rr, s1_z, s2_rr, s2_z, s3_rr, s3_z, s4_rr, s4_z;
  logic signed [AW-1:0] s1_a, s2_a;
  logic signed [AW-1:0] s1_a_next;
  logic signed [RW-1:0] s1_rr_next, s1_z_next;

  always_comb begin
    s1_rr_next = RW'(r0) + RW'(rnd_shift(wide_t'(d_r) *
                 wide_t'($signed({1'b0, point.radius_coord})), COORD_BITS));
    s1_z_next  = RW'(h0) + RW'(rnd_shift(wide_t'(d_h) *
                 wide_t'($signed({1'b0, point.height_coord})), COORD_BITS));
    s1_a_next  = AW'(t0) + AW'(rnd_shift(wide_t'(d_t) *
                 wide_t'($signed({1'b0, point.angle_coord})), COORD_BITS));
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_rr <= s1_rr_next;
      s1_z  <= s1_z_next;
      s1_a  <= s1_a_next;
    end
  end

  // stage 2: turn count estimate, floor(a / 2pi), may fall one short
  logic signed [47:0]   s2_kprod;
  logic signed [KW-1:0] s2_k;

  assign s2_kprod = 48'(s1_a) * TURN_RECIP;

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_rr <= s1_rr;
      s2_z  <= s1_z;
      s2_a  <= s1_a;
      s2_k  <= s2_kprod[TURN_SHIFT +: KW];
    end
  end

  // stage 3: subtract whole turns in Q10.30
  logic signed [QW-1:0] s3_r, s3_r_next;

  assign s3_r_next = (QW'(s2_a) <<< (TRIG_BITS - FRAC_BITS)) - QW'(s2_k) * Q30_TWO_PI;

  always_ff @(posedge clk) begin
    if (en_s3) begin
      s3_rr <= s2_rr;
      s3_z  <= s2_z;
      s3_r  <= s3_r_next;
    end
  end

  // stage 4: wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  logic signed [QW-1:0] s4_wrap, s4_fold;
  logic                 s4_flip_next;
  logic signed [CW-1:0] s4_m;
  logic                 s4_flip;

  always_comb begin
    s4_wrap = s3_r;
    if (s3_r > Q30_PI)       s4_wrap = s3_r - Q30_TWO_PI;
    else if (s3_r < -Q30_PI) s4_wrap = s3_r + Q30_TWO_PI;
    s4_fold      = s4_wrap;
    s4_flip_next = 1'b0;
    if (s4_wrap > Q30_HALF_PI) begin
      s4_fold      = s4_wrap - Q30_PI;
      s4_flip_next = 1'b1;
    end else if (s4_wrap < -Q30_HALF_PI) begin
      s4_fold      = s4_wrap + Q30_PI;
      s4_flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s4) begin
      s4_rr   <= s3_rr;
      s4_z    <= s3_z;
      s4_m    <= s4_fold[CW-1:0];
      s4_flip <= s4_flip_next;
    end
  end

  always_comb begin
    cord_up.x    = Q30_GAIN;
    cord_up.y    = '0;
    cord_up.m    = s4_m;
    cord_up.flip = s4_flip;
    cord_up.rr   = s4_rr;
    cord_up.z    = s4_z;
  end

  cam_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v_s4),
    .up_ready (cord_up_ready),
    .up       (cord_up),
    .dn_valid (cord_dn_valid),
    .dn_ready (en_p1),
    .dn       (cord_dn)
  );

  // P1: radius and span times trig, and the angle span squared
  logic signed [CW-1:0]  p1_c, p1_s;
  logic signed [PRW-1:0] p1_rcos, p1_rsin, p1_dcos, p1_dsin;
  logic signed [31:0]    p1_w;
  logic signed [RW-1:0]  p1_z;

  assign p1_c = cord_dn.flip ? -cord_dn.x : cord_dn.x;
  assign p1_s = cord_dn.flip ? -cord_dn.y : cord_dn.y;

  always_ff @(posedge clk) begin
    if (en_p1) begin
      p1_rcos <= PRW'(rnd_shift(wide_t'(cord_dn.rr) * wide_t'(p1_c), TRIG_BITS));
      p1_rsin <= PRW'(rnd_shift(wide_t'(cord_dn.rr) * wide_t'(p1_s), TRIG_BITS));
      p1_dcos <= PRW'(rnd_shift(wide_t'(d_r) * wide_t'(p1_c), TRIG_BITS));
      p1_dsin <= PRW'(rnd_shift(wide_t'(d_r) * wide_t'(p1_s), TRIG_BITS));
      p1_w    <= 32'(rnd_shift(wide_t'(d_t) * wide_t'(d_t), FRAC_BITS));
      p1_z    <= cord_dn.z;
    end
  end

  // P2: derivative products, saturate into the result register
  result_t result_next;

  always_comb begin
    result_next.pos_x        = sat32(wide_t'(p1_rcos));
    result_next.pos_y        = sat32(wide_t'(p1_rsin));
    result_next.pos_z        = sat32(wide_t'(p1_z));
    result_next.jac_angle_x  = sat32(-rnd_shift(wide_t'(d_t) * wide_t'(p1_rsin), FRAC_BITS));
    result_next.jac_angle_y  = sat32(rnd_shift(wide_t'(d_t) * wide_t'(p1_rcos), FRAC_BITS));
    result_next.jac_radius_x = sat32(wide_t'(p1_dcos));
    result_next.jac_radius_y = sat32(wide_t'(p1_dsin));
    result_next.jac_height_z = sat32(wide_t'(d_h));
    result_next.hess_angle_x = sat32(-rnd_shift(wide_t'(p1_w) * wide_t'(p1_rcos), FRAC_BITS));
    result_next.hess_angle_y = sat32(-rnd_shift(wide_t'(p1_w) * wide_t'(p1_rsin), FRAC_BITS));
    result_next.hess_mixed_x = sat32(-rnd_shift(wide_t'(d_t) * wide_t'(p1_dsin), FRAC_BITS));
    result_next.hess_mixed_y = sat32(rnd_shift(wide_t'(d_t) * wide_t'(p1_dcos), FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en_p2) result <= result_next;
  end

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |=> v_s1)
    else $error("accepted request did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v_s4 && !cord_up_ready |=> v_s4 && $stable(s4_m))
    else $error("stalled angle stage lost its contents");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !v_p1 |=> !result_valid)
    else $error("result repeated after it was taken");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    v_s4 |-> (QW'(s4_m) <= Q30_HALF_PI) && (QW'(s4_m) >= -Q30_HALF_PI))
    else $error("folded angle out of range");
`endif

endmodule
